FILE: rtl/gradient_delta_pixel_reconstruct_assert.svh
// Assertion macros shared by the pixel reconstruction RTL.
`ifndef GRADIENT_DELTA_PIXEL_RECONSTRUCT_ASSERT_SVH
`define GRADIENT_DELTA_PIXEL_RECONSTRUCT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gdpr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GDPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gdpr assertion failed");

`endif

FILE: rtl/gdpr_pkg.sv
// Types, constants and the edge predictor shared by the pixel reconstruction block.
package gdpr_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 65536;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WEFF_W     = COL_W + 1;
	localparam int ROW_W      = 16;
	localparam int FW_W       = 13;
	localparam int FH_W       = 17;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 5;
	localparam int IDX_W      = 3;

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_ADD_DELTA    = 3'd0;
	localparam logic [IDX_W-1:0] REG_USE_GRADIENT = 3'd1;
	localparam logic [IDX_W-1:0] REG_LOW_ABSENT   = 3'd2;
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

	typedef struct packed {
		logic [7:0]  high_residual;
		logic [7:0]  low_byte;
		logic [15:0] delta_pixel;
	} in_t;

	typedef struct packed {
		logic [15:0] pixel_value;
		logic        frame_last;
	} out_t;

	typedef struct packed {
		logic            add_delta;
		logic            use_gradient;
		logic            low_absent;
		logic [FW_W-1:0] frame_width;
		logic [FH_W-1:0] frame_height;
	} cfg_t;

	// Position of the pixel being accepted and what it implies.
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             pred_en;
		logic             last;
	} pos_t;

	// Median edge predictor on rebuilt high bytes, wrapping modulo 256.
	function automatic logic [7:0] med_predict(logic [7:0] n, logic [7:0] w, logic [7:0] nw);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = (n < w) ? n : w;
		hi = (n < w) ? w : n;
		if (nw >= hi) begin
			return lo;
		end else if (nw <= lo) begin
			return hi;
		end else begin
			return 8'(n + w - nw);
		end
	endfunction

endpackage

FILE: rtl/gdpr_regs.sv
// Configuration register file behind the APB-style port.
module gdpr_regs import gdpr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [IDX_W-1:0] idx;
	logic             wr_en;
	cfg_t             cfg_q;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes complete in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.add_delta    <= 1'b0;
			cfg_q.use_gradient <= 1'b0;
			cfg_q.low_absent   <= 1'b0;
			cfg_q.frame_width  <= FW_W'(1);
			cfg_q.frame_height <= FH_W'(1);
		end else if (wr_en) begin
			unique case (idx)
				REG_ADD_DELTA:    cfg_q.add_delta    <= pwdata[0];
				REG_USE_GRADIENT: cfg_q.use_gradient <= pwdata[0];
				REG_LOW_ABSENT:   cfg_q.low_absent   <= pwdata[0];
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data returns the addressed register, zero elsewhere.
	always_comb begin
		unique case (idx)
			REG_ADD_DELTA:    prdata = DATA_W'(cfg_q.add_delta);
			REG_USE_GRADIENT: prdata = DATA_W'(cfg_q.use_gradient);
			REG_LOW_ABSENT:   prdata = DATA_W'(cfg_q.low_absent);
			REG_FRAME_WIDTH:  prdata = DATA_W'(cfg_q.frame_width);
			REG_FRAME_HEIGHT: prdata = DATA_W'(cfg_q.frame_height);
			default:          prdata = '0;
		endcase
	end

endmodule

FILE: rtl/gdpr_line_store.sv
// Line store of rebuilt high bytes, one write and one registered read per cycle.
module gdpr_line_store import gdpr_pkg::*; (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [COL_W-1:0] rd_addr,
	output logic [7:0]       rd_data,
	input  logic             wr_en,
	input  logic [COL_W-1:0] wr_addr,
	input  logic [7:0]       wr_data
);

	logic [7:0] mem [MAX_WIDTH];
	logic [7:0] rd_q;

	assign rd_data = rd_q;

	// A read at the address written in the same cycle returns the old entry.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/gdpr_position.sv
// Raster position counters with row and frame end detection.
module gdpr_position import gdpr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic adv,
	output pos_t pos
);

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [WEFF_W-1:0] w_eff;
	logic [FH_W-1:0]   h_eff;
	logic              row_end;
	logic              frame_end;

	// Clamp the frame size to the supported range.
	always_comb begin
		if (cfg.frame_width == '0) begin
			w_eff = WEFF_W'(1);
		end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
			w_eff = WEFF_W'(MAX_WIDTH);
		end else begin
			w_eff = WEFF_W'(cfg.frame_width);
		end
		if (cfg.frame_height == '0) begin
			h_eff = FH_W'(1);
		end else if (32'(cfg.frame_height) > MAX_HEIGHT) begin
			h_eff = FH_W'(MAX_HEIGHT);
		end else begin
			h_eff = cfg.frame_height;
		end
	end

	assign row_end   = ({1'b0, col_q} + WEFF_W'(1)) >= w_eff;
	assign frame_end = row_end && (({1'b0, row_q} + FH_W'(1)) >= h_eff);

	assign pos.col     = col_q;
	assign pos.row     = row_q;
	assign pos.last    = frame_end;
	assign pos.pred_en = cfg.use_gradient &&
		((row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0)));

	// Step the position once per accepted pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (adv) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

FILE: rtl/gradient_delta_pixel_reconstruct.sv
// Top level of the gradient and delta pixel reconstruction block.
//
// Pixels enter on the in channel (in_valid, in_ready, in_data) in raster order,
// one transaction per pixel, and leave on the out channel (out_valid,
// out_ready, out_data) as 16-bit pixels with a flag on the frame's last pixel.
// The APB-style port sets the modes and the frame size; write it only while
// no pixel is in flight.
// An accepted pixel reads its north byte from the line store in the accept
// cycle, is rebuilt in the rebuild stage and written back as it moves into
// the output register, whose result then forms the output transaction.
// One pixel per cycle is sustained while out_ready stays high, set by the
// single read and single write the line store takes per pixel; a same-column
// read right behind a write is forwarded.
// When out_ready is low, the output register holds its result, one more pixel
// may be accepted into the rebuild stage, and then in_ready drops.
// Reset clears the valid flags, modes, position counters and the west and
// northwest bytes; line store entries hold nothing defined until written.
module gradient_delta_pixel_reconstruct import gdpr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_t               in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_t              out_data
);

	`include "gradient_delta_pixel_reconstruct_assert.svh"

	cfg_t             cfg;
	pos_t             pos;
	logic             in_fire;
	logic             s1_fire;
	logic [7:0]       rd_data;

	logic             s1_valid_q;
	logic [COL_W-1:0] idx_s1;
	in_t              data_s1;
	logic             pred_en_s1;
	logic             last_s1;
	logic             fwd_s1;
	logic [7:0]       fwd_data_s1;

	logic [7:0]       west_q;
	logic [7:0]       northwest_q;
	logic             out_valid_q;
	out_t             out_q;

	logic [7:0]       north;
	logic [7:0]       high_rec;
	logic [7:0]       high_out;
	logic [7:0]       low_out;

	gdpr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gdpr_position u_position (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.adv    (in_fire),
		.pos    (pos)
	);

	gdpr_line_store u_line_store (
		.clk     (clk),
		.rd_en   (in_fire),
		.rd_addr (pos.col),
		.rd_data (rd_data),
		.wr_en   (s1_fire),
		.wr_addr (idx_s1),
		.wr_data (high_rec)
	);

	// Handshake: the rebuild stage moves when the output register is free or drains.
	assign s1_fire   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready  = !s1_valid_q || s1_fire;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Rebuild the high byte, then apply the delta frame and the low plane mode.
	always_comb begin
		north    = fwd_s1 ? fwd_data_s1 : rd_data;
		high_rec = data_s1.high_residual;
		if (pred_en_s1) begin
			high_rec = 8'(data_s1.high_residual + med_predict(north, west_q, northwest_q));
		end
		high_out = high_rec;
		low_out  = cfg.low_absent ? 8'd0 : data_s1.low_byte;
		if (cfg.add_delta) begin
			high_out = 8'(high_out + data_s1.delta_pixel[15:8]);
			low_out  = 8'(low_out + data_s1.delta_pixel[7:0]);
		end
	end

	// Rebuild stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	// Rebuild stage payload, with forwarding of a write to the same column.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			idx_s1      <= pos.col;
			data_s1     <= in_data;
			pred_en_s1  <= pos.pred_en;
			last_s1     <= pos.last;
			fwd_s1      <= s1_fire && (idx_s1 == pos.col);
			fwd_data_s1 <= high_rec;
		end
	end

	// Previous pixel's rebuilt byte and its north byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			west_q      <= '0;
			northwest_q <= '0;
		end else if (s1_fire) begin
			west_q      <= high_rec;
			northwest_q <= north;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= s1_valid_q;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_q.pixel_value <= {high_out, low_out};
			out_q.frame_last  <= last_s1;
		end
	end

	// An empty output register never blocks the input.
	`GDPR_ASSERT_NOW(a_ready_when_out_empty, clk, arst_n, !out_valid_q, in_ready)
	// A full pipeline with a stalled receiver takes no new pixel.
	`GDPR_ASSERT_NOW(a_stall_blocks_input, clk, arst_n,
		s1_valid_q && out_valid_q && !out_ready, !in_ready)
	// The last pixel of a frame sends the position back to the origin.
	`GDPR_ASSERT_NEXT(a_frame_wraps, clk, arst_n, in_fire && pos.last,
		(pos.col == '0) && (pos.row == '0))
	// A pixel accepted while the pixel ahead writes the same column is forwarded.
	`GDPR_ASSERT_NEXT(a_fwd_same_col, clk, arst_n,
		in_fire && s1_fire && (idx_s1 == pos.col), fwd_s1)

endmodule
